[design/sme_pkg.sv]
// Shared types, constants and the range weight table for the sensor conditioner.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps
package sme_pkg;

	localparam int RAW_W       = 12;
	localparam int FRAC_BITS   = 8;
	localparam int VAL_W       = RAW_W + FRAC_BITS;
	localparam int MED_TAPS    = 3;
	localparam int BIL_TAPS    = 5;
	localparam int TAP_CNT_W   = $clog2(BIL_TAPS);
	localparam int WEIGHT_DEPTH = 256;
	localparam int IDX_W       = $clog2(WEIGHT_DEPTH);
	localparam int WEIGHT_W    = 16;
	localparam int WSUM_W      = WEIGHT_W + $clog2(BIL_TAPS);
	localparam int DIV_W       = 40;
	localparam int SCL_Q_W     = 10;
	localparam int QUOT_W      = VAL_W + 1;
	localparam int STEP_W      = $clog2(QUOT_W + 1);
	localparam int ALPHA_W     = 9;
	localparam int SIGMA_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;

	localparam logic [RAW_W-1:0]   FULL_SCALE = {RAW_W{1'b1}};
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 9'd256;
	localparam logic [9:0]         SCALE_FULL = 10'd1000;

	// divider step counts: quotient bits plus one overflow bit
	localparam logic [STEP_W-1:0] IDX_STEPS = STEP_W'(IDX_W + 1);
	localparam logic [STEP_W-1:0] AVG_STEPS = STEP_W'(VAL_W + 1);
	localparam logic [STEP_W-1:0] SCL_STEPS = STEP_W'(SCL_Q_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EMA_ALPHA     = 3'd0,
		REG_CAL_MIN       = 3'd1,
		REG_CAL_MAX       = 3'd2,
		REG_SPATIAL_LIMIT = 3'd3,
		REG_RANGE_SIGMA   = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MED, S_EMA1, S_EMA2, S_INS, S_TAP, S_IDX, S_MAC,
		S_AVG, S_AVGW, S_SCL, S_SCL2, S_SCLW, S_OUT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  dsh;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef logic [WEIGHT_W-1:0] weight_rom_t [WEIGHT_DEPTH];

	// exp(-n) in Q30 for whole n
	function automatic longint unsigned exp_int_q30(longint unsigned n);
		longint unsigned r;
		case (n)
			0: r = 64'd1073741824;
			1: r = 64'd395007542;
			2: r = 64'd145315154;
			3: r = 64'd53458458;
			4: r = 64'd19666268;
			5: r = 64'd7234815;
			6: r = 64'd2661540;
			default: r = 64'd979126;
		endcase
		return r;
	endfunction

	// long division by compare and subtract, truncating
	function automatic longint unsigned udiv_exact(longint unsigned n, longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			r = (r << 1) | ((n >> b) & 64'd1);
			if (r >= d) begin
				r = r - d;
				q = q | (64'd1 << b);
			end
		end
		return q;
	endfunction

	// exp(-t) in Q30, t in Q30; series for the fractional part
	function automatic longint unsigned exp_neg_q30(longint unsigned t);
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint          sum;
		n    = t >> 30;
		f    = t & ((64'd1 << 30) - 64'd1);
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		if (n > 7)
			return 64'd0;
		for (int k = 1; k <= 12; k++) begin
			term = udiv_exact((term * f) >> 30, longint'(k));
			if (k % 2 == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		return (exp_int_q30(n) * longint'(unsigned'(sum))) >> 30;
	endfunction

	// Gaussian weights exp(-x*x/2), x = 4*i/DEPTH, Q0.16 rounded and saturated
	function automatic weight_rom_t build_weights();
		weight_rom_t     rom;
		longint unsigned t;
		longint unsigned w;
		for (int i = 0; i < WEIGHT_DEPTH; i++) begin
			t = ((64'd8 * longint'(i) * longint'(i)) << 30) >> (2 * IDX_W);
			w = (exp_neg_q30(t) + (64'd1 << 13)) >> 14;
			rom[i] = (w > 64'd65535) ? 16'hFFFF : w[WEIGHT_W-1:0];
		end
		return rom;
	endfunction

	localparam weight_rom_t WEIGHT_ROM = build_weights();

endpackage

[design/sensor_median_ema_bilateral_scaler.sv]
// Sensor channel conditioner: median of three, EMA, bilateral filter, scaling.
// Depends on sme_pkg, sme_tap_cell and sme_div.
//
// Usage: items enter on the s_ stream. s_tuser is the mode: 0 filters the
// sample in s_tdata, 1 loads the EMA state with cal_min and gives no result.
// Each filtered sample gives one result item on the m_ stream with the
// scaled position, the bilateral output, the median and a rejected flag.
// Registers are written on the cfg channel, which is always ready; write
// them only while no item is in flight.
// Timing: one item at a time. A seed item is taken in idle and the block
// stays there. A sample passes median and EMA, then a step for each window
// tap, with a weight index division in the shared bit-serial divider for each
// tap within the spatial limit (the centre tap always is), the division for
// the weighted average, the scaling with its division when it runs, the load
// of the output register and the return to idle.
// s_tready rises again once the result sits in the output register.
// A stalled receiver holds the result; the next item is worked on and waits
// for the output register to empty.
// Reset clears all windows, the tap counter and the EMA state to zero and loads
// the register defaults; the weight table is constant logic.
`timescale 1ns / 1ps
module sensor_median_ema_bilateral_scaler (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] raw_sample, [15:12] zero
	input  logic        s_tuser,   // [0] mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [9:0] scaled_tenths, [29:10] filtered_value,
	                               // [41:30] median_value, [47:42] zero
	output logic        m_tuser    // [0] rejected
);
	import sme_pkg::*;

	// configuration
	logic [ALPHA_W-1:0] alpha_q;
	logic [VAL_W-1:0]   cal_min_q;
	logic [VAL_W-1:0]   cal_max_q;
	logic [RAW_W-1:0]   limit_q;
	logic [SIGMA_W-1:0] sigma_q;

	// state
	state_t             state_q, state_d;
	logic [RAW_W-1:0]   med_win_q [MED_TAPS];
	logic [RAW_W-1:0]   med_q;
	logic               rej_q;
	logic [28:0]        p1_q;
	logic [VAL_W-1:0]   ema_q;
	logic [TAP_CNT_W-1:0] tap_cnt_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [DIV_W-1:0]   vsum_q;
	logic [WSUM_W-1:0]  wsum_q;
	logic [VAL_W-1:0]   filt_q;
	logic signed [31:0] num_q;
	logic signed [20:0] den_q;
	logic [9:0]         scl_q;

	// output register
	logic               out_valid_q;
	logic [9:0]         out_scaled_q;
	logic [VAL_W-1:0]   out_filt_q;
	logic [RAW_W-1:0]   out_med_q;
	logic               out_rej_q;

	// control
	logic     in_fire;
	logic     chain_insert;
	logic     chain_rotate;
	logic     tap_last;
	logic     out_free;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// datapath signals
	logic [ALPHA_W-1:0] alpha_eff;
	logic [SIGMA_W-1:0] sigma_eff;
	logic [RAW_W-1:0]   med_new;
	logic [RAW_W-1:0]   lo01, hi01;
	logic [29:0]        ema_sum;
	logic [VAL_W-1:0]   cell_val   [BIL_TAPS];
	logic [VAL_W-1:0]   cell_delta [BIL_TAPS];
	logic               cell_near  [BIL_TAPS];
	logic [VAL_W-1:0]   chain_head;
	logic [VAL_W-1:0]   head_val;
	logic signed [20:0] diff_s;
	logic signed [20:0] den_raw;
	logic signed [20:0] one_s;
	logic               sign_clash;
	logic [31:0]        abs_num;
	logic [20:0]        abs_den;
	logic [9:0]         scaled;

	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign tap_last  = (tap_cnt_q == TAP_CNT_W'(BIL_TAPS - 1));
	assign alpha_eff = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign sigma_eff = (sigma_q == '0) ? SIGMA_W'(1) : sigma_q;
	assign head_val  = cell_val[BIL_TAPS-1];
	assign one_s     = 21'sd1 <<< FRAC_BITS;

	// median of the window after this sample is stored
	always_comb begin
		logic [RAW_W-1:0] a, b, c;
		a = med_win_q[0];
		b = med_win_q[1];
		c = med_win_q[2];
		lo01 = (a < b) ? a : b;
		hi01 = (a < b) ? b : a;
		med_new = (lo01 > ((hi01 < c) ? hi01 : c)) ? lo01 : ((hi01 < c) ? hi01 : c);
	end

	assign ema_sum = {1'b0, p1_q} + 30'(30'(ALPHA_ONE - alpha_eff) * 30'(ema_q)) + 30'd128;

	// scaling operands
	assign diff_s  = $signed({1'b0, filt_q}) - $signed({1'b0, cal_min_q});
	assign den_raw = $signed({1'b0, cal_max_q}) - $signed({1'b0, cal_min_q});
	assign sign_clash = (num_q != 32'sd0) && (num_q[31] != den_q[20]);
	assign abs_num = num_q[31] ? 32'(-num_q) : 32'(num_q);
	assign abs_den = den_q[20] ? 21'(-den_q) : 21'(den_q);
	assign scaled  = (div_rsp.quot[SCL_Q_W] || (div_rsp.quot[SCL_Q_W-1:0] > SCALE_FULL))
		? SCALE_FULL : div_rsp.quot[SCL_Q_W-1:0];

	// bilateral window: a chain of tap cells, rotated once per tap
	assign chain_head = chain_insert ? ema_q : cell_val[BIL_TAPS-1];

	for (genvar i = 0; i < BIL_TAPS; i++) begin : g_tap
		sme_tap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (chain_insert || chain_rotate),
			.din    ((i == 0) ? chain_head : cell_val[(i == 0) ? 0 : i - 1]),
			.centre (ema_q),
			.limit  ({limit_q, {FRAC_BITS{1'b0}}}),
			.value  (cell_val[i]),
			.delta  (cell_delta[i]),
			.near   (cell_near[i])
		);
	end

	sme_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		chain_insert = 1'b0;
		chain_rotate = 1'b0;
		div_req      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (in_fire && !s_tuser) begin
					state_d = S_MED;
				end
			end
			S_MED:  state_d = S_EMA1;
			S_EMA1: state_d = S_EMA2;
			S_EMA2: state_d = S_INS;
			S_INS: begin
				chain_insert = 1'b1;
				state_d      = S_TAP;
			end
			S_TAP: begin
				if (cell_near[BIL_TAPS-1]) begin
					div_req.start = 1'b1;
					div_req.num   = DIV_W'(cell_delta[BIL_TAPS-1]) << (8 + IDX_W);
					div_req.dsh   = DIV_W'(sigma_eff) << (2 + FRAC_BITS + IDX_W);
					div_req.steps = IDX_STEPS;
					state_d       = S_IDX;
				end else begin
					chain_rotate = 1'b1;
					state_d      = tap_last ? S_AVG : S_TAP;
				end
			end
			S_IDX: begin
				if (div_rsp.done) begin
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				chain_rotate = 1'b1;
				state_d      = tap_last ? S_AVG : S_TAP;
			end
			S_AVG: begin
				if (wsum_q == '0) begin
					state_d = S_SCL;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = vsum_q + DIV_W'(wsum_q >> 1);
					div_req.dsh   = DIV_W'(wsum_q) << VAL_W;
					div_req.steps = AVG_STEPS;
					state_d       = S_AVGW;
				end
			end
			S_AVGW: begin
				if (div_rsp.done) begin
					state_d = S_SCL;
				end
			end
			S_SCL: state_d = S_SCL2;
			S_SCL2: begin
				if (sign_clash) begin
					state_d = S_OUT;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_W'(abs_num) + DIV_W'(abs_den >> 1);
					div_req.dsh   = DIV_W'(abs_den) << SCL_Q_W;
					div_req.steps = SCL_STEPS;
					state_d       = S_SCLW;
				end
			end
			S_SCLW: begin
				if (div_rsp.done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= 9'd38;
			cal_min_q <= 20'd524032;
			cal_max_q <= 20'd524032;
			limit_q   <= 12'd200;
			sigma_q   <= 16'd13;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_EMA_ALPHA:     alpha_q   <= cfg_data[ALPHA_W-1:0];
				REG_CAL_MIN:       cal_min_q <= cfg_data[VAL_W-1:0];
				REG_CAL_MAX:       cal_max_q <= cfg_data[VAL_W-1:0];
				REG_SPATIAL_LIMIT: limit_q   <= cfg_data[RAW_W-1:0];
				REG_RANGE_SIGMA:   sigma_q   <= cfg_data[SIGMA_W-1:0];
				default: ;
			endcase
		end
	end

	// filter state: median window, EMA and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MED_TAPS; i++) begin
				med_win_q[i] <= '0;
			end
			ema_q     <= '0;
			tap_cnt_q <= '0;
		end else begin
			if (in_fire && s_tuser) begin
				ema_q <= cal_min_q;
			end else if (in_fire && (s_tdata[RAW_W-1:0] != FULL_SCALE)) begin
				med_win_q[0] <= s_tdata[RAW_W-1:0];
				for (int i = 1; i < MED_TAPS; i++) begin
					med_win_q[i] <= med_win_q[i-1];
				end
			end
			if (state_q == S_EMA2) begin
				ema_q <= ema_sum[VAL_W+7:8];
			end
			if (state_q == S_INS) begin
				tap_cnt_q <= '0;
			end else if (chain_rotate) begin
				tap_cnt_q <= tap_cnt_q + 1'b1;
			end
		end
	end

	// arithmetic registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rej_q <= (s_tdata[RAW_W-1:0] == FULL_SCALE);
		end
		if (state_q == S_MED) begin
			med_q <= med_new;
		end
		if (state_q == S_EMA1) begin
			p1_q <= 29'(alpha_eff) * 29'({med_q, {FRAC_BITS{1'b0}}});
		end
		if (state_q == S_INS) begin
			vsum_q <= '0;
			wsum_q <= '0;
		end
		if (state_q == S_IDX && div_rsp.done) begin
			w_q <= div_rsp.quot[IDX_W] ? '0 : WEIGHT_ROM[div_rsp.quot[IDX_W-1:0]];
		end
		if (state_q == S_MAC) begin
			vsum_q <= vsum_q + DIV_W'(36'(head_val) * 36'(w_q));
			wsum_q <= wsum_q + WSUM_W'(w_q);
		end
		if (state_q == S_AVG && wsum_q == '0) begin
			filt_q <= ema_q;
		end
		if (state_q == S_AVGW && div_rsp.done) begin
			filt_q <= div_rsp.quot[VAL_W-1:0];
		end
		if (state_q == S_SCL) begin
			num_q <= 32'(diff_s) * 32'sd1000;
			if (den_raw > -one_s && den_raw < one_s) begin
				den_q <= (den_raw >= 21'sd0) ? one_s : -one_s;
			end else begin
				den_q <= den_raw;
			end
		end
		if (state_q == S_SCL2 && sign_clash) begin
			scl_q <= '0;
		end
		if (state_q == S_SCLW && div_rsp.done) begin
			scl_q <= scaled;
		end
		if (state_q == S_OUT && out_free) begin
			out_scaled_q <= scl_q;
			out_filt_q   <= filt_q;
			out_med_q    <= med_q;
			out_rej_q    <= rej_q;
		end
	end

	// output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_med_q, out_filt_q, out_scaled_q};
	assign m_tuser  = out_rej_q;

`ifndef SYNTH
	// a seed item loads the EMA state from cal_min
	a_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser) |=> (ema_q == $past(cal_min_q)))
		else $error("EMA seed not loaded");

	// the scaled position never exceeds full travel
	a_scale_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:0] <= SCALE_FULL))
		else $error("scaled value above 1000");

	// taps are accumulated only within the window
	a_tap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) |-> (tap_cnt_q < TAP_CNT_W'(BIL_TAPS)))
		else $error("tap counter out of range");

	// divider results arrive only while a division is awaited
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_IDX || state_q == S_AVGW || state_q == S_SCLW))
		else $error("stray divider result");
`endif

endmodule

[design/sme_tap_cell.sv]
// One tap of the bilateral window: holds a value, passes it on along the chain.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_tap_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic [sme_pkg::VAL_W-1:0] din,
	input  logic [sme_pkg::VAL_W-1:0] centre,
	input  logic [sme_pkg::VAL_W-1:0] limit,
	output logic [sme_pkg::VAL_W-1:0] value,
	output logic [sme_pkg::VAL_W-1:0] delta,
	output logic                      near
);
	import sme_pkg::*;

	logic [VAL_W-1:0] value_q;

	// take the neighbor's value on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (shift) begin
			value_q <= din;
		end
	end

	// distance to the centre and the spatial gate
	always_comb begin
		delta = (value_q > centre) ? (value_q - centre) : (centre - value_q);
		near  = (delta <= limit);
	end

	assign value = value_q;

endmodule

[design/sme_div.sv]
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on sme_pkg.
`timescale 1ns / 1ps
module sme_div (
	input  logic              clk,
	input  logic              arst_n,
	input  sme_pkg::div_req_t req,
	output sme_pkg::div_rsp_t rsp
);
	import sme_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic              ge;

	assign ge = (rem_q >= dsh_q);

	// compare, subtract and shift the divisor down once per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= req.dsh;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? (rem_q - dsh_q) : rem_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

[bench/sensor_median_ema_bilateral_scaler_tb.sv]
// Self-checking bench for the sensor conditioner: directed table, then random phases.
// Depends on sme_pkg and sensor_median_ema_bilateral_scaler; predicts every result itself but for fixed table rows.
`timescale 1ns / 1ps
module sensor_median_ema_bilateral_scaler_tb;
	import sme_pkg::*;

	typedef struct packed {
		logic [9:0]  tenths;
		logic [19:0] filt;
		logic [11:0] med;
		logic        rej;
	} cond_res_t;

	typedef struct packed {
		logic        md;
		logic [11:0] raw;
		logic        fixed;
		cond_res_t   want;
	} dir_row_t;

	localparam int DIR_ROWS = 19;
	localparam longint unsigned VMASK = (64'd1 << VAL_W) - 64'd1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;

	// predictor copy of registers and state
	longint unsigned alpha_r, cmin_r, cmax_r, limit_r, sigma_r;
	longint unsigned mwin [3];
	int              mptr;
	longint unsigned ema_q;
	longint unsigned bwin [5];
	int              bptr;
	longint unsigned gauss_q16 [WEIGHT_DEPTH];

	cond_res_t pending_res [$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        items_sent = 0;
	int        max_gap = 13;
	bit        hold_req = 1'b0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{1'b0, 12'd0,    1'b1, '{10'd0, 20'd0, 12'd0, 1'b0}},
		'{1'b0, 12'd4095, 1'b1, '{10'd0, 20'd0, 12'd0, 1'b1}},
		'{1'b0, 12'd4095, 1'b0, '0},
		'{1'b0, 12'd4094, 1'b0, '0},
		'{1'b0, 12'd1,    1'b0, '0},
		'{1'b0, 12'd2048, 1'b0, '0},
		'{1'b0, 12'd2048, 1'b0, '0},
		'{1'b0, 12'd2048, 1'b0, '0},
		'{1'b0, 12'd4000, 1'b0, '0},
		'{1'b0, 12'd2048, 1'b0, '0},
		'{1'b1, 12'd4095, 1'b0, '0},
		'{1'b0, 12'd100,  1'b0, '0},
		'{1'b0, 12'd0,    1'b0, '0},
		'{1'b1, 12'd0,    1'b0, '0},
		'{1'b0, 12'd3000, 1'b0, '0},
		'{1'b0, 12'd3000, 1'b0, '0},
		'{1'b0, 12'd3000, 1'b0, '0},
		'{1'b0, 12'd1,    1'b0, '0},
		'{1'b0, 12'd4094, 1'b0, '0}
	};

	sensor_median_ema_bilateral_scaler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	// exp(-t), Q30 in and out, integer part from constants and series for the rest
	function automatic longint unsigned exp_q30(longint unsigned t);
		longint unsigned ipart [8];
		longint unsigned n;
		longint unsigned f;
		longint unsigned term;
		longint          acc;
		ipart = '{64'd1073741824, 64'd395007542, 64'd145315154, 64'd53458458,
			64'd19666268, 64'd7234815, 64'd2661540, 64'd979126};
		n = t >> 30;
		f = t & ((64'd1 << 30) - 1);
		term = 64'd1 << 30;
		acc = 64'sd1 << 30;
		if (n > 7)
			return 0;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * f) >> 30) / k;
			if (k & 1)
				acc -= longint'(term);
			else
				acc += longint'(term);
		end
		return (ipart[n] * longint'(unsigned'(acc))) >> 30;
	endfunction

	task automatic fill_gauss();
		longint unsigned t;
		longint unsigned w;
		for (int i = 0; i < WEIGHT_DEPTH; i++) begin
			t = ((64'd8 * i * i) << 30) / (WEIGHT_DEPTH * WEIGHT_DEPTH);
			w = (exp_q30(t) + (64'd1 << 13)) >> 14;
			gauss_q16[i] = (w > 65535) ? 65535 : w;
		end
	endtask

	// predict one accepted item: advance the state, return the result if any
	task automatic predict_cond(input logic md, input logic [11:0] raw,
			output bit has, output cond_res_t r);
		longint unsigned a, b, c, med, g, lim, den, ws, vs, d, idx, w, filt, an, ad, q;
		longint          sd, sn, one;
		has = 1'b0;
		r = '0;
		if (md) begin
			ema_q = cmin_r & VMASK;
			return;
		end
		has = 1'b1;
		r.rej = (raw == FULL_SCALE);
		if (!r.rej) begin
			mwin[mptr] = raw;
			mptr = (mptr + 1) % 3;
		end
		a = mwin[0]; b = mwin[1]; c = mwin[2];
		med = (a < b) ? ((b < c) ? b : ((a < c) ? c : a)) : ((a < c) ? a : ((b < c) ? c : b));
		g = (alpha_r > 256) ? 256 : alpha_r;
		ema_q = ((g * (med << FRAC_BITS) + (256 - g) * ema_q + 128) >> 8) & VMASK;
		bwin[bptr] = ema_q;
		bptr = (bptr + 1) % 5;
		// range-weighted average around the new EMA value
		lim = limit_r << FRAC_BITS;
		den = (4 * ((sigma_r == 0) ? 1 : sigma_r)) << FRAC_BITS;
		ws = 0; vs = 0;
		for (int i = 0; i < 5; i++) begin
			d = (bwin[i] > ema_q) ? bwin[i] - ema_q : ema_q - bwin[i];
			if (d <= lim) begin
				idx = ((d << 8) * WEIGHT_DEPTH) / den;
				w = (idx < WEIGHT_DEPTH) ? gauss_q16[idx] : 0;
				ws += w;
				vs += bwin[i] * w;
			end
		end
		filt = ((ws == 0) ? ema_q : (vs + ws / 2) / ws) & VMASK;
		// map onto 0..1000 with clamp
		one = 64'sd1 << FRAC_BITS;
		sd = longint'(cmax_r) - longint'(cmin_r);
		sn = (longint'(filt) - longint'(cmin_r)) * 1000;
		if (sd > -one && sd < one)
			sd = (sd >= 0) ? one : -one;
		if (sn != 0 && ((sn < 0) != (sd < 0))) begin
			q = 0;
		end else begin
			an = (sn < 0) ? -sn : sn;
			ad = (sd < 0) ? -sd : sd;
			q = (an + ad / 2) / ad;
			if (q > 1000)
				q = 1000;
		end
		r.tenths = q[9:0];
		r.filt = filt[19:0];
		r.med = med[11:0];
	endtask

	// write one register and mirror it; the caller drops valid
	task automatic write_reg(input cfg_reg_t idx, input longint unsigned val);
		cfg_index <= idx;
		cfg_data <= val[19:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_EMA_ALPHA:     alpha_r = val & 64'h1FF;
			REG_CAL_MIN:       cmin_r = val & 64'hFFFFF;
			REG_CAL_MAX:       cmax_r = val & 64'hFFFFF;
			REG_SPATIAL_LIMIT: limit_r = val & 64'hFFF;
			REG_RANGE_SIGMA:   sigma_r = val & 64'hFFFF;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_all(input longint unsigned al, mn, mx, lm, sg);
		write_reg(REG_EMA_ALPHA, al);
		write_reg(REG_CAL_MIN, mn);
		write_reg(REG_CAL_MAX, mx);
		write_reg(REG_SPATIAL_LIMIT, lm);
		write_reg(REG_RANGE_SIGMA, sg);
		cfg_valid <= 1'b0;
	endtask

	// offer one item after a random gap; push its prediction on acceptance
	task automatic send_item(input logic md, input logic [11:0] raw,
			input bit fixed, input cond_res_t want);
		int        gap;
		bit        has;
		cond_res_t r;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tuser <= md;
		s_tdata <= {4'd0, raw};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_cond(md, raw, has, r);
		if (has)
			pending_res.push_back(fixed ? want : r);
		items_sent++;
		@(negedge clk);
	endtask

	// wait until every expected result has come, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	// receiver: random stall per item, one long hold on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (700) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				w = $urandom_range(0, max_gap);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(negedge clk);
				end
				m_tready <= 1'b1;
			end
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		cond_res_t got;
		cond_res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[9:0], m_tdata[29:10], m_tdata[41:30], m_tuser};
			results_seen++;
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", got);
			end else begin
				exp_r = pending_res.pop_front();
				if (got !== exp_r) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp tenths %0d filt %0d med %0d rej %0d,",
							exp_r.tenths, exp_r.filt, exp_r.med, exp_r.rej);
						$display("          got tenths %0d filt %0d med %0d rej %0d",
							got.tenths, got.filt, got.med, got.rej);
					end
				end
			end
		end
	end

	initial begin
		#30_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int        lvl, rnd, raw_i;
		cond_res_t none;
		none = '0;
		alpha_r = 38; cmin_r = 524032; cmax_r = 524032; limit_r = 200; sigma_r = 13;
		mwin = '{0, 0, 0}; mptr = 0; ema_q = 0; bwin = '{0, 0, 0, 0, 0}; bptr = 0;
		fill_gauss();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table under reset defaults
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_tab[i].md, dir_tab[i].raw, dir_tab[i].fixed, dir_tab[i].want);
		drain();

		// random phases: extremes first, then random settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: write_all(256, 0, 1048575, 4095, 65535);
				1: write_all(0, 1048575, 0, 0, 0);
				2: write_all(511, 1000 << 8, 3000 << 8, 50, 300);
				3: write_all(1, 2000 << 8, 2000 << 8, 4095, 1);
				default: write_all($urandom_range(0, 300), $urandom_range(0, 1048575),
					$urandom_range(0, 1048575), $urandom_range(0, 400),
					$urandom_range(0, 3000));
			endcase
			max_gap = (ph == 4) ? 0 : 13;
			lvl = $urandom_range(0, 4094);
			for (int k = 0; k < 200; k++) begin
				if (ph == 2 && k == 60)
					drain();
				if (ph == 3 && k == 20)
					hold_req = 1'b1;
				rnd = $urandom_range(0, 99);
				// mostly a slowly moving level with noise, some spikes and seeds
				lvl = lvl + $urandom_range(0, 40) - 20;
				if (lvl < 0) lvl = 0;
				if (lvl > 4094) lvl = 4094;
				raw_i = lvl + $urandom_range(0, 16) - 8;
				if (raw_i < 0) raw_i = 0;
				if (raw_i > 4094) raw_i = 4094;
				if (rnd < 8)
					send_item(1'b1, 12'($urandom_range(0, 4095)), 1'b0, none);
				else if (rnd < 13)
					send_item(1'b0, FULL_SCALE, 1'b0, none);
				else if (rnd < 28)
					send_item(1'b0, 12'($urandom_range(0, 4095)), 1'b0, none);
				else
					send_item(1'b0, 12'(raw_i), 1'b0, none);
			end
			drain();
		end

		$display("covered %0d items and %0d results over 8 register settings,", items_sent,
			results_seen);
		$display("with seeds, full-scale rejects, a long output hold and a full drain pause");
		if (mismatches == 0 && pending_res.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
